// ----- rtl/vdib_pkg.sv -----
`timescale 1ns / 1ps
package vdib_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int HASH_SLOTS   = 8192;
  localparam int SLOT_W       = $clog2(HASH_SLOTS);
  localparam int IDX_W        = 12;
  localparam int CNT_W        = 13;
  localparam int NORM_W       = 24;
  localparam int KEY_W        = 2 * NORM_W;
  localparam int RAM_W        = 1 + KEY_W + IDX_W;
  localparam int NUM_W        = 57;
  localparam int DEN_W        = 34;
  localparam int PROD_W       = 32 + SLOT_W;
  localparam int MUL_STEPS    = (PROD_W < KEY_W) ? PROD_W : KEY_W;
  localparam int STEP_W       = $clog2(MUL_STEPS);

  localparam logic [NORM_W-1:0] QUANT     = 24'd10000000;
  localparam logic [63:0]       HASH_MULT = 64'h9E3779B97F4A7C15;

  typedef enum logic [1:0] {
    OP_ACCUM  = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_INDEX  = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_EXTENT = 3'd1,
    ST_NO_BOX     = 3'd2,
    ST_FULL       = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } front_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_t;

  typedef struct packed {
    status_t                status;
    logic [IDX_W-1:0]       vertex_index;
    logic                   is_new;
    logic [NORM_W-1:0]      norm_x;
    logic [NORM_W-1:0]      norm_y;
    logic signed [33:0]     corner_x2;
    logic signed [33:0]     corner_y2;
    logic [31:0]            side;
    logic [CNT_W-1:0]       total;
  } result_t;

endpackage

// ----- rtl/vdib_ram.sv -----
`timescale 1ns / 1ps
module vdib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/vdib_div.sv -----
`timescale 1ns / 1ps
module vdib_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [vdib_pkg::NUM_W-1:0] num,
  input  logic [vdib_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [vdib_pkg::NORM_W-1:0] quo
);
  import vdib_pkg::*;

  logic [DEN_W-1:0]  rem_r;
  logic [NORM_W-1:0] low_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    trial;
  logic              ge;
  logic [DEN_W:0]    diff;

  // quotient fits in NORM_W bits, so the top part of num is already below den
  assign trial = {rem_r, low_r[NORM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};
  assign done  = done_r;
  assign quo   = low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !go && busy_r && (cnt_r == 5'd1);
      if (go) begin
        rem_r  <= {1'b0, num[NUM_W-1:NORM_W]};
        low_r  <= num[NORM_W-1:0];
        cnt_r  <= 5'(NORM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_r <= {low_r[NORM_W-2:0], ge};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/vdib_front.sv -----
`timescale 1ns / 1ps
module vdib_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_x,
  input  logic [31:0]        in_y,
  output logic               in_ready,
  output vdib_pkg::front_t   fr,
  input  vdib_pkg::back_t    bk
);
  import vdib_pkg::*;

  item_t      q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;
  item_t      item_in;

  // classify the raw item into a typed operation
  always_comb begin
    item_in.op = op_t'(in_op);
    item_in.x  = $signed(in_x);
    item_in.y  = $signed(in_y);
  end

  assign in_ready = (cnt_r != 2'd2) && !bk.clearing;
  assign push     = in_valid && in_ready;
  assign pop      = bk.pop && (cnt_r != 2'd0);
  assign fr.valid = cnt_r != 2'd0;
  assign fr.item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= item_in;
        wr_ptr_r      <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/vdib_core.sv -----
`timescale 1ns / 1ps
module vdib_core (
  input  logic                clk,
  input  logic                rst_n,
  input  vdib_pkg::front_t    fr,
  output vdib_pkg::back_t     bk,
  output logic                out_valid,
  input  logic                out_ready,
  output vdib_pkg::result_t   out_res
);
  import vdib_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_QMUL, S_QDIV, S_HASH, S_PRB_RD, S_PRB_CHK, S_OUT
  } state_t;

  state_t              state_r;
  logic signed [31:0]  lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic signed [33:0]  cx2_r, cy2_r;
  logic [31:0]         side_r;
  logic                box_r;
  logic [CNT_W-1:0]    dist_r;
  logic                any_idx_r;
  item_t               cur_r;
  logic                sel_r;
  logic [NORM_W-1:0]   nx_r, ny_r;
  logic [NUM_W-1:0]    num_r;
  logic                div_go_r;
  logic [KEY_W-1:0]    key_sh_r;
  logic [PROD_W-1:0]   mc_r, acc_r;
  logic [STEP_W-1:0]   step_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                pend_r;
  result_t             res_r;
  result_t             out_r;
  logic                out_valid_r;

  // close datapath
  logic signed [32:0]  ex, ey;
  logic [31:0]         s_c;
  logic signed [33:0]  s34, cx2_c, cy2_c;
  logic                no_pts;
  // quantize datapath
  logic signed [31:0]  p_c;
  logic signed [33:0]  c2_c;
  logic signed [34:0]  off_c;
  logic [32:0]         two_side;
  logic [32:0]         u_c;
  logic [NUM_W-1:0]    num_c;
  // hash and probe
  logic [PROD_W-1:0]   acc_nxt;
  logic                div_done;
  logic [NORM_W-1:0]   div_quo;
  logic                ram_we;
  logic [RAM_W-1:0]    ram_wdata, ram_rdata;
  logic                rd_used;
  logic [KEY_W-1:0]    rd_key;
  logic [IDX_W-1:0]    rd_idx;
  logic                hit, can_ins;

  assign no_pts = (lo_x_r > hi_x_r) || (lo_y_r > hi_y_r);
  assign ex     = 33'(hi_x_r) - 33'(lo_x_r);
  assign ey     = 33'(hi_y_r) - 33'(lo_y_r);
  assign s_c    = (ex > ey) ? ex[31:0] : ey[31:0];
  assign s34    = $signed({2'b00, s_c});
  assign cx2_c  = 34'(lo_x_r) + 34'(hi_x_r) - s34;
  assign cy2_c  = 34'(lo_y_r) + 34'(hi_y_r) - s34;

  assign p_c      = sel_r ? cur_r.y : cur_r.x;
  assign c2_c     = sel_r ? cy2_r : cx2_r;
  assign off_c    = 35'(p_c) * 35'sd2 - 35'(c2_c);
  assign two_side = {side_r, 1'b0};
  always_comb begin
    if (off_c < 0) begin
      u_c = '0;
    end else if (off_c > $signed({2'b00, two_side})) begin
      u_c = two_side;
    end else begin
      u_c = off_c[32:0];
    end
  end
  assign num_c = 57'(u_c) * 57'(QUANT) + 57'(side_r);

  assign acc_nxt = key_sh_r[0] ? acc_r + mc_r : acc_r;

  assign rd_used = ram_rdata[RAM_W-1];
  assign rd_key  = ram_rdata[IDX_W +: KEY_W];
  assign rd_idx  = ram_rdata[IDX_W-1:0];
  assign hit     = rd_used && (rd_key == {nx_r, ny_r});
  assign can_ins = !rd_used && (dist_r < CNT_W'(MAX_VERTICES));

  assign ram_we    = (state_r == S_CLEAR) || ((state_r == S_PRB_CHK) && can_ins);
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : {1'b1, nx_r, ny_r, dist_r[IDX_W-1:0]};

  assign bk.pop      = (state_r == S_IDLE) && fr.valid;
  assign bk.clearing = state_r == S_CLEAR;
  assign out_valid   = out_valid_r;
  assign out_res     = out_r;

  vdib_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go_r),
    .num  (num_r),
    .den  ({1'b0, two_side}),
    .done (div_done),
    .quo  (div_quo)
  );

  vdib_ram #(.WIDTH(RAM_W), .DEPTH(HASH_SLOTS)) u_tab (
    .clk  (clk),
    .we   (ram_we),
    .addr (slot_r),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      slot_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      res_r       <= '0;
      lo_x_r      <= 32'sh7FFFFFFF;
      lo_y_r      <= 32'sh7FFFFFFF;
      hi_x_r      <= 32'sh80000000;
      hi_y_r      <= 32'sh80000000;
      cx2_r       <= '0;
      cy2_r       <= '0;
      side_r      <= '0;
      box_r       <= 1'b0;
      dist_r      <= '0;
      any_idx_r   <= 1'b0;
    end else begin
      div_go_r <= state_r == S_QMUL;
      if (!out_valid_r || out_ready) begin
        out_valid_r <= state_r == S_OUT;
      end
      unique case (state_r)
        S_CLEAR: begin
          slot_r <= slot_r + 1'b1;
          if (slot_r == {SLOT_W{1'b1}}) begin
            state_r <= pend_r ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (fr.valid) begin
            unique case (fr.item.op)
              OP_ACCUM: begin
                if (fr.item.x < lo_x_r) lo_x_r <= fr.item.x;
                if (fr.item.x > hi_x_r) hi_x_r <= fr.item.x;
                if (fr.item.y < lo_y_r) lo_y_r <= fr.item.y;
                if (fr.item.y > hi_y_r) hi_y_r <= fr.item.y;
              end
              OP_CLOSE: begin
                dist_r    <= '0;
                any_idx_r <= 1'b0;
                if (no_pts || (s_c == '0)) begin
                  box_r        <= 1'b0;
                  res_r.status <= ST_BAD_EXTENT;
                end else begin
                  side_r          <= s_c;
                  cx2_r           <= cx2_c;
                  cy2_r           <= cy2_c;
                  box_r           <= 1'b1;
                  res_r.corner_x2 <= cx2_c;
                  res_r.corner_y2 <= cy2_c;
                  res_r.side      <= s_c;
                end
                pend_r  <= 1'b1;
                slot_r  <= '0;
                state_r <= S_CLEAR;
              end
              OP_INDEX: begin
                if (!box_r) begin
                  res_r.status <= ST_NO_BOX;
                  state_r      <= S_OUT;
                end else begin
                  cur_r   <= fr.item;
                  sel_r   <= 1'b0;
                  state_r <= S_QMUL;
                end
              end
              OP_FINISH: begin
                res_r.status <= any_idx_r ? ST_OK : ST_EMPTY;
                res_r.total  <= dist_r;
                lo_x_r       <= 32'sh7FFFFFFF;
                lo_y_r       <= 32'sh7FFFFFFF;
                hi_x_r       <= 32'sh80000000;
                hi_y_r       <= 32'sh80000000;
                box_r        <= 1'b0;
                any_idx_r    <= 1'b0;
                state_r      <= S_OUT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_QMUL: begin
          num_r   <= num_c;
          state_r <= S_QDIV;
        end
        S_QDIV: begin
          if (div_done) begin
            if (!sel_r) begin
              nx_r    <= div_quo;
              sel_r   <= 1'b1;
              state_r <= S_QMUL;
            end else begin
              ny_r     <= div_quo;
              key_sh_r <= {nx_r, div_quo};
              acc_r    <= '0;
              mc_r     <= HASH_MULT[PROD_W-1:0];
              step_r   <= '0;
              state_r  <= S_HASH;
            end
          end
        end
        S_HASH: begin
          // shift-add multiply, one key bit per cycle
          acc_r    <= acc_nxt;
          mc_r     <= mc_r << 1;
          key_sh_r <= key_sh_r >> 1;
          step_r   <= step_r + 1'b1;
          if (step_r == STEP_W'(MUL_STEPS - 1)) begin
            slot_r  <= acc_nxt[PROD_W-1 -: SLOT_W];
            state_r <= S_PRB_RD;
          end
        end
        S_PRB_RD: begin
          state_r <= S_PRB_CHK;
        end
        S_PRB_CHK: begin
          res_r.norm_x <= nx_r;
          res_r.norm_y <= ny_r;
          if (hit) begin
            res_r.status       <= ST_OK;
            res_r.vertex_index <= rd_idx;
            any_idx_r          <= 1'b1;
            state_r            <= S_OUT;
          end else if (rd_used) begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_PRB_RD;
          end else if (can_ins) begin
            res_r.status       <= ST_OK;
            res_r.vertex_index <= dist_r[IDX_W-1:0];
            res_r.is_new       <= 1'b1;
            dist_r             <= dist_r + 1'b1;
            any_idx_r          <= 1'b1;
            state_r            <= S_OUT;
          end else begin
            res_r.status <= ST_FULL;
            state_r      <= S_OUT;
          end
        end
        S_OUT: begin
          pend_r <= 1'b0;
          if (!out_valid_r || out_ready) begin
            out_r   <= res_r;
            res_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !bk.pop)
    else $error("item popped during table clear");
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dist_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond table limit");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_QDIV))
    else $error("divider finished outside quantize");
  a_write_clear_or_new: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == S_PRB_CHK)) |=> (state_r == S_OUT && res_r.is_new))
    else $error("table write without new vertex");
`endif

endmodule

// ----- rtl/vertex_dedup_index_builder.sv -----
`timescale 1ns / 1ps
// Vertex welding index builder.
// Input channel in_*: one item per handshake carrying an operation and a point.
// Accumulate widens the bounding box and returns nothing. Close squares the box,
// returns it, and wipes the vertex table. Index quantizes the point to 1e-7 of
// the box side and looks it up in an 8192-slot hash table, returning its index.
// Finish returns the distinct vertex count and resets the box.
// Output channel out_*: one item per close, index and finish.
// Index runs two quantize steps, x then y (a multiply, then a radix-2 divide
// on a shared divider), then a shift-add hash multiply, then probes the table
// RAM, a read and then a check per probe; items are handled one at a time.
// Close and reset both run a table clearing pass over all 8192 entries, one
// RAM entry per cycle; in_tready stays low through it. A two-item queue in
// front keeps taking items while the back end works. When the receiver
// stalls the result holds in the output register; the back end waits on the
// next result only.
module vertex_dedup_index_builder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] operation, [33:2] coord_x, [65:34] coord_y
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [14:3] vertex_index, [15] is_new, [39:16] norm_x,
  // [63:40] norm_y, [97:64] box_corner_x2, [131:98] box_corner_y2,
  // [163:132] box_side, [176:164] vertex_total
  output logic [183:0] out_tdata
);
  import vdib_pkg::*;

  front_t  fr;
  back_t   bk;
  result_t res;

  vdib_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_op   (in_tdata[1:0]),
    .in_x    (in_tdata[33:2]),
    .in_y    (in_tdata[65:34]),
    .in_ready(in_tready),
    .fr      (fr),
    .bk      (bk)
  );

  vdib_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fr       (fr),
    .bk       (bk),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {7'd0, res.total, res.side, res.corner_y2, res.corner_x2,
                      res.norm_y, res.norm_x, res.is_new, res.vertex_index,
                      res.status};

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import vdib_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int TAIL_CYCLES    = 300;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [71:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [183:0] out_tdata;

  vertex_dedup_index_builder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mirror of the block state
  longint          bnd_lo_x, bnd_hi_x, bnd_lo_y, bnd_hi_y;
  longint          sq_corner_x2, sq_corner_y2;
  longint unsigned sq_side;
  bit              sq_ready;
  int unsigned     vert_count;
  int unsigned     lookup_count;
  bit              slot_busy [HASH_SLOTS];
  bit [47:0]       slot_pair [HASH_SLOTS];
  int unsigned     slot_vert [HASH_SLOTS];

  result_t results_due[$];
  int      errors;
  int      items_sent;
  int      results_seen;
  int      idle_cycles;
  int      rx_wait;
  int      rx_hold;
  bit      no_gaps;

  function automatic void bounds_to_reset();
    bnd_lo_x = 64'sh7FFFFFFF;
    bnd_lo_y = 64'sh7FFFFFFF;
    bnd_hi_x = -64'sh80000000;
    bnd_hi_y = -64'sh80000000;
  endfunction

  function automatic logic [NORM_W-1:0] quantize_coord(longint p, longint c2);
    longint          off;
    longint unsigned u;
    longint unsigned two_side;
    off = 2 * p - c2;
    two_side = 2 * sq_side;
    if (off < 0) off = 0;
    u = off;
    if (u > two_side) u = two_side;
    return NORM_W'((u * 10000000 + sq_side) / two_side);
  endfunction

  // Returns 1 when the operation yields a result
  function automatic bit predict_mesh_op(op_t op, longint x, longint y,
                                         output result_t r);
    longint          ex, ey, s;
    logic [NORM_W-1:0] nx, ny;
    bit [47:0]       pair;
    longint unsigned prod;
    int unsigned     h, sl;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ACCUM: begin
        if (x < bnd_lo_x) bnd_lo_x = x;
        if (x > bnd_hi_x) bnd_hi_x = x;
        if (y < bnd_lo_y) bnd_lo_y = y;
        if (y > bnd_hi_y) bnd_hi_y = y;
        return 1'b0;
      end
      OP_CLOSE: begin
        for (int i = 0; i < HASH_SLOTS; i++) slot_busy[i] = 1'b0;
        vert_count = 0;
        lookup_count = 0;
        sq_ready = 1'b0;
        if (bnd_lo_x > bnd_hi_x || bnd_lo_y > bnd_hi_y) begin
          r.status = ST_BAD_EXTENT;
          return 1'b1;
        end
        ex = bnd_hi_x - bnd_lo_x;
        ey = bnd_hi_y - bnd_lo_y;
        s = (ex > ey) ? ex : ey;
        if (s == 0) begin
          r.status = ST_BAD_EXTENT;
          return 1'b1;
        end
        sq_side = s;
        sq_corner_x2 = bnd_lo_x + bnd_hi_x - s;
        sq_corner_y2 = bnd_lo_y + bnd_hi_y - s;
        sq_ready = 1'b1;
        r.corner_x2 = sq_corner_x2[33:0];
        r.corner_y2 = sq_corner_y2[33:0];
        r.side = s[31:0];
        return 1'b1;
      end
      OP_INDEX: begin
        if (!sq_ready) begin
          r.status = ST_NO_BOX;
          return 1'b1;
        end
        nx = quantize_coord(x, sq_corner_x2);
        ny = quantize_coord(y, sq_corner_y2);
        r.norm_x = nx;
        r.norm_y = ny;
        pair = {nx, ny};
        prod = longint'(pair) * HASH_MULT;
        h = prod[44:32];
        for (int p = 0; p < HASH_SLOTS; p++) begin
          sl = (h + p) % HASH_SLOTS;
          if (slot_busy[sl]) begin
            if (slot_pair[sl] == pair) begin
              r.vertex_index = slot_vert[sl][IDX_W-1:0];
              if (lookup_count != 32'hFFFFFFFF) lookup_count++;
              return 1'b1;
            end
          end else begin
            if (vert_count >= MAX_VERTICES) break;
            slot_busy[sl] = 1'b1;
            slot_pair[sl] = pair;
            slot_vert[sl] = vert_count;
            r.vertex_index = vert_count[IDX_W-1:0];
            r.is_new = 1'b1;
            vert_count++;
            if (lookup_count != 32'hFFFFFFFF) lookup_count++;
            return 1'b1;
          end
        end
        r.status = ST_FULL;
        return 1'b1;
      end
      default: begin
        r.status = (lookup_count == 0) ? ST_EMPTY : ST_OK;
        r.total = vert_count[CNT_W-1:0];
        bounds_to_reset();
        sq_ready = 1'b0;
        lookup_count = 0;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic send_item(op_t op, logic signed [31:0] x, logic signed [31:0] y);
    int      gap;
    result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {6'b0, y, x, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (predict_mesh_op(op, longint'(x), longint'(y), r)) results_due.push_back(r);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      rx_wait = no_gaps ? 0 : $urandom_range(0, 3);
      if (results_due.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        exp_r = results_due.pop_front();
        if (out_tdata[2:0] !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_tdata[2:0]); errors++;
        end
        if (out_tdata[14:3] !== exp_r.vertex_index) begin
          $error("vertex_index exp %0d got %0d", exp_r.vertex_index, out_tdata[14:3]);
          errors++;
        end
        if (out_tdata[15] !== exp_r.is_new) begin
          $error("is_new exp %0d got %0d", exp_r.is_new, out_tdata[15]); errors++;
        end
        if (out_tdata[39:16] !== exp_r.norm_x) begin
          $error("norm_x exp %0d got %0d", exp_r.norm_x, out_tdata[39:16]); errors++;
        end
        if (out_tdata[63:40] !== exp_r.norm_y) begin
          $error("norm_y exp %0d got %0d", exp_r.norm_y, out_tdata[63:40]); errors++;
        end
        if (out_tdata[97:64] !== exp_r.corner_x2) begin
          $error("box_corner_x2 exp %h got %h", exp_r.corner_x2, out_tdata[97:64]);
          errors++;
        end
        if (out_tdata[131:98] !== exp_r.corner_y2) begin
          $error("box_corner_y2 exp %h got %h", exp_r.corner_y2, out_tdata[131:98]);
          errors++;
        end
        if (out_tdata[163:132] !== exp_r.side) begin
          $error("box_side exp %0d got %0d", exp_r.side, out_tdata[163:132]); errors++;
        end
        if (out_tdata[176:164] !== exp_r.total) begin
          $error("vertex_total exp %0d got %0d", exp_r.total, out_tdata[176:164]);
          errors++;
        end
      end
    end
  end

  // Receiver: per-result wait, plus an optional long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready = 1'b0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_tready = 1'b0;
        rx_wait--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_no_box();
    send_item(OP_INDEX, 32'sd5, 32'sd7);
    send_item(OP_FINISH, 0, 0);
    send_item(OP_CLOSE, 0, 0);
    send_item(OP_INDEX, -32'sd1, 32'sd1);
    send_item(OP_ACCUM, 32'sd42, -32'sd42);
    send_item(OP_CLOSE, 0, 0);
    send_item(OP_INDEX, 32'sd42, -32'sd42);
    send_item(OP_FINISH, 0, 0);
  endtask

  task automatic test_extremes();
    send_item(OP_ACCUM, 32'sh80000000, 32'sh80000000);
    send_item(OP_ACCUM, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_item(OP_CLOSE, 0, 0);
    send_item(OP_INDEX, 32'sh80000000, 32'sh7FFFFFFF);
    send_item(OP_INDEX, 32'sh7FFFFFFF, 32'sh80000000);
    send_item(OP_INDEX, 32'sh80000000, 32'sh7FFFFFFF);
    send_item(OP_INDEX, 0, -32'sd1);
    send_item(OP_FINISH, 0, 0);
    // narrow box; outside points saturate, odd side hits the half-up rounding
    send_item(OP_ACCUM, 32'sd0, 32'sd0);
    send_item(OP_ACCUM, 32'sd3, 32'sd1);
    send_item(OP_CLOSE, 0, 0);
    send_item(OP_INDEX, 32'sh80000000, 32'sh7FFFFFFF);
    send_item(OP_INDEX, 32'sd1, 32'sd2);
    send_item(OP_INDEX, 32'sd2, 32'sd1);
    send_item(OP_INDEX, 32'sd1, 32'sd2);
    send_item(OP_FINISH, 0, 0);
    send_item(OP_FINISH, 0, 0);
  endtask

  task automatic test_backpressure();
    wait_results_done();
    rx_hold = 400;
    for (int i = 0; i < 12; i++) send_item(i[0] ? OP_FINISH : OP_INDEX, i, -i);
    wait_results_done();
    repeat (20) @(negedge clk);
  endtask

  function automatic logic signed [31:0] mesh_coord(longint base, int unsigned span);
    longint v;
    v = base + longint'($urandom_range(0, span));
    if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
    return v[31:0];
  endfunction

  task automatic test_random_meshes();
    longint            bx, by;
    int unsigned       span;
    int                n_acc, n_idx;
    logic signed [31:0] px [$];
    logic signed [31:0] py [$];
    int                k;
    while (items_sent < 760) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      bx = $signed($urandom());
      by = $signed($urandom());
      case ($urandom_range(0, 3))
        0: span = $urandom_range(1, 8);
        1: span = $urandom_range(1, 5000);
        2: span = $urandom();
        default: span = $urandom_range(0, 1);
      endcase
      px.delete();
      py.delete();
      n_acc = $urandom_range(0, 6);
      for (int i = 0; i < n_acc; i++) begin
        px.push_back(mesh_coord(bx, span));
        py.push_back(mesh_coord(by, span));
        send_item(OP_ACCUM, px[i], py[i]);
      end
      if ($urandom_range(0, 5) == 0) send_item(op_t'($urandom_range(0, 3)),
                                               $urandom(), $urandom());
      send_item(OP_CLOSE, 0, 0);
      n_idx = 3 * $urandom_range(0, 6);
      for (int i = 0; i < n_idx; i++) begin
        k = $urandom_range(0, 3);
        if (k == 0 || px.size() == 0) send_item(OP_INDEX, $urandom(), $urandom());
        else if (k == 1) send_item(OP_INDEX, mesh_coord(bx, span), mesh_coord(by, span));
        else begin
          k = $urandom_range(0, px.size() - 1);
          send_item(OP_INDEX, px[k], py[k]);
        end
      end
      if ($urandom_range(0, 7) != 0) send_item(OP_FINISH, $urandom(), $urandom());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    rx_wait = 0;
    rx_hold = 0;
    no_gaps = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    rst_n = 1'b0;
    bounds_to_reset();
    sq_corner_x2 = 0;
    sq_corner_y2 = 0;
    sq_side = 0;
    sq_ready = 1'b0;
    vert_count = 0;
    lookup_count = 0;
    for (int i = 0; i < HASH_SLOTS; i++) slot_busy[i] = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_no_box();
    test_extremes();
    test_backpressure();
    test_random_meshes();

    wait_results_done();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("sent %0d items, checked %0d results: bounds, close, index with", items_sent,
             results_seen);
    $display("dedup, finish, under random gaps and a long output stall");
    if (errors == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/vdib_pkg.sv
rtl/vdib_ram.sv
rtl/vdib_div.sv
rtl/vdib_front.sv
rtl/vdib_core.sv
rtl/vertex_dedup_index_builder.sv
tb/sv/tb_top.sv
